@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int CMD_W     = 2;
  localparam int TAG_W     = 32;
  localparam int PRIO_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CLR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic                     clr;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                     occ;
    logic                     cmp;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } link_t;

  // left of the head cell: always occupied, never beaten
  localparam link_t LINK_HEAD = '{occ: 1'b1, cmp: 1'b0, tag: '0, prio: '0};
  // right of the tail cell: empty
  localparam link_t LINK_TAIL = '{occ: 1'b0, cmp: 1'b1, tag: '0, prio: '0};

endpackage

@@ design/spq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::CMD_W-1:0]        cmd;
  logic [spq_pkg::TAG_W-1:0]        payload;
  logic signed [spq_pkg::PRIO_W-1:0] prio;

  modport source (output valid, cmd, payload, prio, input ready);
  modport sink   (input valid, cmd, payload, prio, output ready);
endinterface

interface spq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::TAG_W-1:0]     out_payload;
  logic                          out_valid;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::OCC_W-1:0]     occupancy;
  logic                          is_empty;
  logic                          is_full;

  modport source (output valid, out_payload, out_valid, status, occupancy, is_empty,
                  is_full, input ready);
  modport sink   (input valid, out_payload, out_valid, status, occupancy, is_empty,
                  is_full, output ready);
endinterface

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert and
// left on removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::link_t     left,
  input  spq_pkg::link_t     right,
  output spq_pkg::link_t     self
);

  logic                             occ;
  logic [spq_pkg::TAG_W-1:0]        tag;
  logic signed [spq_pkg::PRIO_W-1:0] prio;
  logic                             cmp;

  // chain is sorted, so cmp is a thermometer; insert point is where it rises
  assign cmp = !occ || (ctl.prio > prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clr) begin
      occ <= 1'b0;
    end else if (ctl.enq) begin
      occ <= left.occ;
    end else if (ctl.deq) begin
      occ <= right.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enq && cmp) begin
      if (left.cmp) begin
        tag  <= left.tag;
        prio <= left.prio;
      end else begin
        tag  <= ctl.tag;
        prio <= ctl.prio;
      end
    end else if (ctl.deq) begin
      tag  <= right.tag;
      prio <= right.prio;
    end
  end

  assign self = '{occ: occ, cmp: cmp, tag: tag, prio: prio};

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (occ && right.occ) |-> (prio >= right.prio))
    else $error("chain out of order");

  a_occ_contig: assert property (@(posedge clk) disable iff (rst)
    occ |-> left.occ)
    else $error("hole in occupied cells");

  a_clr_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |=> !occ)
    else $error("cell still occupied after clear");

endmodule

@@ design/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept in descending priority order in a row of cells.
// ----------------------------------------------------------------------------
// Takes one request (enqueue, dequeue, clear) per clock and returns its
// response in the next cycle from an output register; a request is taken
// while the response register is empty or being drained. Every cell decides
// its own move from its local compare and its left neighbor's compare, so
// all cells move at once on an insert or a removal, whatever the fill, with
// equal priorities leaving first-in, first-out. Full enqueues and empty
// dequeues leave the queue alone and report an error status. No clearing
// pass is needed after reset.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 full;
  logic                 empty;
  logic                 acc;
  spq_pkg::cell_ctl_t   ctl;
  spq_pkg::link_t       lnk [DEPTH];
  logic [DEPTH-1:0]     occ_vec;
  spq_pkg::status_t     st_next;
  logic                 ov_next;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign req.ready = !rsp.valid || rsp.ready;
  assign acc = req.valid && req.ready;

  always_comb begin
    ctl      = '{enq: 1'b0, deq: 1'b0, clr: 1'b0, tag: req.payload, prio: req.prio};
    count_next = count;
    st_next  = spq_pkg::ST_OK;
    ov_next  = 1'b0;
    if (acc) begin
      unique case (spq_pkg::cmd_t'(req.cmd))
        spq_pkg::CMD_ENQ: begin
          if (full) begin
            st_next = spq_pkg::ST_FULL;
          end else begin
            ctl.enq    = 1'b1;
            count_next = count + 1'b1;
          end
        end
        spq_pkg::CMD_DEQ: begin
          if (empty) begin
            st_next = spq_pkg::ST_EMPTY;
          end else begin
            ctl.deq    = 1'b1;
            ov_next    = 1'b1;
            count_next = count - 1'b1;
          end
        end
        spq_pkg::CMD_CLR: begin
          ctl.clr    = 1'b1;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_pkg::link_t lft;
      spq_pkg::link_t rgt;
      if (gi == 0) begin : g_head
        assign lft = spq_pkg::LINK_HEAD;
      end else begin : g_mid_l
        assign lft = lnk[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign rgt = spq_pkg::LINK_TAIL;
      end else begin : g_mid_r
        assign rgt = lnk[gi+1];
      end
      spq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .left  (lft),
        .right (rgt),
        .self  (lnk[gi])
      );
      assign occ_vec[gi] = lnk[gi].occ;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.out_payload <= ov_next ? lnk[0].tag : '0;
      rsp.out_valid   <= ov_next;
      rsp.status      <= st_next;
      rsp.occupancy   <= spq_pkg::OCC_W'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CNT_W'(DEPTH));
    end
  end

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("cell occupancy disagrees with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count above capacity");

  a_deq_head: assert property (@(posedge clk) disable iff (rst)
    (acc && ctl.deq) |=> (rsp.out_valid && rsp.out_payload == $past(lnk[0].tag)))
    else $error("dequeue did not return head");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    (acc && req.cmd == spq_pkg::CMD_DEQ && empty) |=>
      (rsp.valid && rsp.status == spq_pkg::ST_EMPTY && !rsp.out_valid))
    else $error("empty dequeue not flagged");

endmodule

@@ bench/sorted_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Requests go in on the request channel and responses come back on the
// response channel. Both channels idle at random. A shadow copy of the
// queue predicts each response. The bench checks the dequeued tag, the
// status, the occupancy and the flags of every response against that copy.
// The run starts with directed corner cases. Random phases follow that
// fill, drain and mix the queue. There is one long response stall and one
// full drain pause.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEF;
  localparam int N_RANDOM    = 600;
  localparam int HOLD_CYCLES = 80;
  localparam int WDOG_LIMIT  = 5000;
  localparam logic [spq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;  // unused code, no operation

  typedef struct packed {
    logic [spq_pkg::TAG_W-1:0]    payload;
    logic                         vld;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]    occ;
    logic                         empty;
    logic                         full;
  } queue_rsp_t;

  class spq_scoreboard;
    logic [spq_pkg::TAG_W-1:0]         shadow_tag [QDEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [QDEPTH];
    int                                shadow_fill;
    queue_rsp_t                        due_rsp [$];
    int                                errors;

    function new();
      shadow_fill = 0;
      errors      = 0;
    endfunction

    function int pending();
      return due_rsp.size();
    endfunction

    function void note_request(logic [spq_pkg::CMD_W-1:0] cmd,
                               logic [spq_pkg::TAG_W-1:0] tag,
                               logic signed [spq_pkg::PRIO_W-1:0] pr);
      queue_rsp_t r;
      int pos;
      int i;
      r = '0;
      r.status = spq_pkg::ST_OK;
      case (cmd)
        spq_pkg::CMD_ENQ: begin
          if (shadow_fill >= QDEPTH) begin
            r.status = spq_pkg::ST_FULL;
          end else begin
            // new entry goes ahead of the first strictly lower priority
            pos = shadow_fill;
            for (i = 0; i < shadow_fill && pos == shadow_fill; i++)
              if (pr > shadow_prio[i]) pos = i;
            for (i = shadow_fill; i > pos; i--) begin
              shadow_tag[i]  = shadow_tag[i-1];
              shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_tag[pos]  = tag;
            shadow_prio[pos] = pr;
            shadow_fill++;
          end
        end
        spq_pkg::CMD_DEQ: begin
          if (shadow_fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
          end else begin
            r.payload = shadow_tag[0];
            r.vld     = 1'b1;
            for (i = 0; i + 1 < shadow_fill; i++) begin
              shadow_tag[i]  = shadow_tag[i+1];
              shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_fill--;
          end
        end
        spq_pkg::CMD_CLR: shadow_fill = 0;
        default: ;
      endcase
      r.occ   = spq_pkg::OCC_W'(shadow_fill);
      r.empty = (shadow_fill == 0);
      r.full  = (shadow_fill == QDEPTH);
      due_rsp.push_back(r);
    endfunction

    function void compare_field(string name, logic [spq_pkg::TAG_W-1:0] want,
                                logic [spq_pkg::TAG_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_response(queue_rsp_t got);
      queue_rsp_t want;
      if (due_rsp.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, expected none, actual %h",
                 $time, got);
      end else begin
        want = due_rsp.pop_front();
        compare_field("out_payload", want.payload, got.payload);
        compare_field("out_valid", spq_pkg::TAG_W'(want.vld), spq_pkg::TAG_W'(got.vld));
        compare_field("status", spq_pkg::TAG_W'(want.status), spq_pkg::TAG_W'(got.status));
        compare_field("occupancy", spq_pkg::TAG_W'(want.occ), spq_pkg::TAG_W'(got.occ));
        compare_field("is_empty", spq_pkg::TAG_W'(want.empty), spq_pkg::TAG_W'(got.empty));
        compare_field("is_full", spq_pkg::TAG_W'(want.full), spq_pkg::TAG_W'(got.full));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic no_idle  = 1'b0;
  logic hold_rsp = 1'b0;
  int   idle_cycles;

  spq_scoreboard sb = new();

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: response checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response('{payload: rsp_ch.out_payload, vld: rsp_ch.out_valid,
                            status: rsp_ch.status, occ: rsp_ch.occupancy,
                            empty: rsp_ch.is_empty, full: rsp_ch.is_full});
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.cmd, req_ch.payload, req_ch.prio);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // response side
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 7);
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [spq_pkg::CMD_W-1:0] cmd,
                              input logic [spq_pkg::TAG_W-1:0] tag,
                              input logic signed [spq_pkg::PRIO_W-1:0] pr);
    if (!no_idle && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= cmd;
    req_ch.payload <= tag;
    req_ch.prio    <= pr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int mode);
    int roll;
    logic [spq_pkg::CMD_W-1:0] cmd;
    logic signed [spq_pkg::PRIO_W-1:0] pr;
    roll = $urandom_range(99);
    // mode 0 fills, mode 1 drains, mode 2 mixes
    if (roll < 2)
      cmd = spq_pkg::CMD_CLR;
    else if (roll < 3)
      cmd = CMD_NOP;
    else if (mode == 0)
      cmd = (roll < 88) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
    else if (mode == 1)
      cmd = (roll < 18) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
    else
      cmd = (roll < 52) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
    // narrow priorities give lots of ties
    if ($urandom_range(1))
      pr = spq_pkg::PRIO_W'($urandom);
    else
      pr = spq_pkg::PRIO_W'($urandom_range(6)) - 16'sd3;
    send_request(cmd, $urandom, pr);
  endtask

  initial begin
    int mode;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.cmd     <= spq_pkg::CMD_ENQ;
    req_ch.payload <= '0;
    req_ch.prio    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner cases on an empty queue
    send_request(spq_pkg::CMD_DEQ, 32'h0, 16'sd0);
    send_request(CMD_NOP, 32'h0, 16'sd0);
    send_request(spq_pkg::CMD_CLR, 32'h0, 16'sd0);
    // extremes and ties: expected order F.., D, A, B, C, 0
    send_request(spq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 16'sh7FFF);
    send_request(spq_pkg::CMD_ENQ, 32'h0000_0000, 16'sh8000);
    send_request(spq_pkg::CMD_ENQ, 32'h0000_000A, 16'sd0);
    send_request(spq_pkg::CMD_ENQ, 32'h0000_000B, 16'sd0);
    send_request(spq_pkg::CMD_ENQ, 32'h0000_000C, -16'sd1);
    send_request(spq_pkg::CMD_ENQ, 32'h0000_000D, 16'sh7FFF);
    send_request(CMD_NOP, 32'hDEAD_BEEF, 16'sd5);
    repeat (6) send_request(spq_pkg::CMD_DEQ, 32'h0, 16'sd0);
    send_request(spq_pkg::CMD_DEQ, 32'h0, 16'sd0);
    send_request(spq_pkg::CMD_ENQ, 32'h5555_AAAA, 16'sh5555);
    send_request(spq_pkg::CMD_ENQ, 32'hAAAA_5555, 16'shAAAA);
    send_request(spq_pkg::CMD_CLR, 32'h0, 16'sd0);
    send_request(spq_pkg::CMD_DEQ, 32'h0, 16'sd0);
    send_request(spq_pkg::CMD_ENQ, 32'h1234_5678, 16'sd1);
    send_request(spq_pkg::CMD_DEQ, 32'h0, 16'sd0);

    mode = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) mode = (n == 0) ? 0 : $urandom_range(2);
      if (n == 200) hold_rsp = 1'b1;
      if (n == 350) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      no_idle = (n >= 420 && n < 520);
      send_random(mode);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
